### rtl/core/srf_pkg.sv
// Shared constants and controller/datapath types for the sequence replay filter.
package srf_pkg;

	localparam int FUNC_W = 2;
	localparam int SEQ_W  = 8;
	localparam int TIME_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000;

	typedef struct packed {
		logic latch_req;
		logic ram_rd;
		logic commit_wr;
		logic sweep_wr;
		logic load_result;
		logic sel_cmp;
	} srf_cmd_t;

	typedef struct packed {
		logic op_check_hit;
		logic op_commit_hit;
		logic op_clear;
		logic sweep_last;
	} srf_status_t;

endpackage

### rtl/core/srf_req_if.sv
// Request channel: operation, sequence number and current time.
interface srf_req_if;
	logic                       valid;
	logic                       ready;
	logic [srf_pkg::FUNC_W-1:0] func;
	logic [srf_pkg::SEQ_W-1:0]  sequence_req;
	logic [srf_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, func, sequence_req, now_ms, input ready);
	modport sink (input valid, func, sequence_req, now_ms, output ready);
endinterface

### rtl/core/srf_rsp_if.sv
// Response channel: duplicate flag.
interface srf_rsp_if;
	logic valid;
	logic ready;
	logic duplicate;

	modport source (output valid, duplicate, input ready);
	modport sink (input valid, duplicate, output ready);
endinterface

### rtl/core/srf_cfg_if.sv
// Configuration write channel for the replay window register.
interface srf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [srf_pkg::TIME_W-1:0] replay_window_ms;

	modport source (output valid, replay_window_ms, input ready);
	modport sink (input valid, replay_window_ms, output ready);
endinterface

### rtl/core/srf_ram.sv
// Generic simple dual-port RAM with registered read.
module srf_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/srf_dp.sv
// Datapath: entry RAM, sweep counter, age compare, window and result registers.
module srf_dp #(
	parameter int SEQ_ENTRIES = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [srf_pkg::FUNC_W-1:0] func,
	input  logic [srf_pkg::SEQ_W-1:0]  sequence_req,
	input  logic [srf_pkg::TIME_W-1:0] now_ms,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [srf_pkg::TIME_W-1:0] cfg_window,
	input  srf_pkg::srf_cmd_t          cmd,
	output srf_pkg::srf_status_t       st,
	output logic                       duplicate
);
	import srf_pkg::*;

	localparam int IDX_W   = $clog2(SEQ_ENTRIES);
	localparam int ENTRY_W = TIME_W + 1;

	logic [16:0]        seq_wide;
	logic               in_table;
	logic [IDX_W-1:0]   req_addr;
	logic [IDX_W-1:0]   sweep_cnt_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  window_q;
	logic               dup_q;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [TIME_W-1:0]  age;
	logic               dup_cmp;

	assign seq_wide = {9'd0, sequence_req};
	assign in_table = seq_wide < 17'(SEQ_ENTRIES);
	assign req_addr = seq_wide[IDX_W-1:0];

	assign st.op_check_hit  = (func == FUNC_CHECK) && in_table;
	assign st.op_commit_hit = (func == FUNC_COMMIT) && in_table;
	assign st.op_clear      = (func == FUNC_CLEAR);
	assign st.sweep_last    = (sweep_cnt_q == IDX_W'(SEQ_ENTRIES - 1));

	// sweep writes the valid bit low, commit writes {valid, time}
	assign ram_we    = cmd.commit_wr | cmd.sweep_wr;
	assign ram_waddr = cmd.sweep_wr ? sweep_cnt_q : req_addr;
	assign ram_wdata = cmd.sweep_wr ? '0 : {1'b1, now_ms};

	srf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SEQ_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.ram_rd),
		.raddr (req_addr),
		.rdata (ram_rdata)
	);

	assign age     = now_q - ram_rdata[TIME_W-1:0];
	assign dup_cmp = ram_rdata[TIME_W] && (age <= window_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
			window_q    <= WINDOW_RESET;
		end else begin
			if (cmd.sweep_wr) begin
				sweep_cnt_q <= st.sweep_last ? '0 : sweep_cnt_q + 1'b1;
			end
			if (cfg_valid) begin
				window_q <= cfg_window;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			now_q <= now_ms;
		end
		if (cmd.load_result) begin
			dup_q <= cmd.sel_cmp ? dup_cmp : 1'b0;
		end
	end

	assign cfg_ready = 1'b1;
	assign duplicate = dup_q;

endmodule

### rtl/core/srf_ctrl.sv
// Controller: init sweep, request sequencing, clear sweep and response valid.
module srf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  srf_pkg::srf_status_t st,
	output srf_pkg::srf_cmd_t    cmd
);
	import srf_pkg::*;

	typedef enum logic [4:0] {
		ST_INIT   = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_LOOKUP = 5'b00100,
		ST_SWEEP  = 5'b01000,
		ST_FINISH = 5'b10000
	} srf_state_t;

	srf_state_t state_q, state_nxt;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (st.sweep_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					if (st.op_check_hit) begin
						cmd.ram_rd = 1'b1;
						state_nxt  = ST_LOOKUP;
					end else if (st.op_commit_hit) begin
						cmd.commit_wr = 1'b1;
						state_nxt     = ST_FINISH;
					end else if (st.op_clear) begin
						state_nxt = ST_SWEEP;
					end else begin
						state_nxt = ST_FINISH;
					end
				end
			end
			ST_LOOKUP: begin
				if (slot_free) begin
					cmd.load_result = 1'b1;
					cmd.sel_cmp     = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (st.sweep_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.load_result = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_result) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result never overwrites one still waiting
	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> slot_free)
		else $error("result loaded over pending transfer");

	// table lookup always follows an in-range check
	a_check_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && st.op_check_hit) |=> (state_q == ST_LOOKUP))
		else $error("check did not enter lookup");

	// one item in flight: no back-to-back request transfers
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while item in flight");

	// clear sweep ends in a result
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && st.sweep_last) |=> (state_q == ST_FINISH))
		else $error("clear sweep did not finish");

endmodule

### rtl/core/sequence_replay_filter_unit.sv
// Sequence replay filter top level: controller, datapath and channel hookup.
// Each request transfer yields one response transfer. A check does a registered
// entry RAM read, then a 32-bit wrapping age compare against the window; a clear
// sweeps all SEQ_ENTRIES entries, as the entry RAM's single write port drops one
// valid bit per cycle. After reset a clearing pass over all SEQ_ENTRIES entries
// runs with request ready low. Responses sit in an output register, so a new
// request is taken while the previous response waits. The window register
// write channel is always ready and should be used only while the block is idle.
module sequence_replay_filter_unit #(
	parameter int SEQ_ENTRIES = 256
) (
	input logic      clk,
	input logic      arst_n,
	srf_req_if.sink  req,
	srf_rsp_if.source rsp,
	srf_cfg_if.sink  cfg
);
	import srf_pkg::*;

	srf_cmd_t    cmd;
	srf_status_t st;

	srf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	srf_dp #(
		.SEQ_ENTRIES (SEQ_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.func         (req.func),
		.sequence_req (req.sequence_req),
		.now_ms       (req.now_ms),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_window   (cfg.replay_window_ms),
		.cmd          (cmd),
		.st           (st),
		.duplicate    (rsp.duplicate)
	);

endmodule

### test/replay_filter_checker.sv
// Checker for the sequence replay filter: watches the channels, predicts and compares.
`timescale 1ns / 100ps

module replay_filter_checker #(
	parameter int SEQ_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	srf_req_if          req,
	srf_rsp_if          rsp,
	srf_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned hits,
	output int unsigned pending
);
	import srf_pkg::*;

	bit                entry_seen [SEQ_ENTRIES];
	logic [TIME_W-1:0] stamp [SEQ_ENTRIES];
	logic [TIME_W-1:0] window;
	bit                dup_expected [$];

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Applies one request to the shadow table; returns the duplicate flag it should produce.
	function automatic bit apply_request(input logic [FUNC_W-1:0] f,
			input logic [SEQ_W-1:0] s, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] age;
		bit                hit;
		hit = 1'b0;
		case (f)
			FUNC_CHECK: begin
				if (s < SEQ_ENTRIES && entry_seen[s]) begin
					age = t - stamp[s];
					hit = (age <= window);
				end
			end
			FUNC_COMMIT: begin
				if (s < SEQ_ENTRIES) begin
					stamp[s] = t;
					entry_seen[s] = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				foreach (entry_seen[i]) entry_seen[i] = 1'b0;
			end
			default: ;
		endcase
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit exp_dup;
		if (!arst_n) begin
			foreach (entry_seen[i]) entry_seen[i] = 1'b0;
			window = WINDOW_RESET;
			dup_expected.delete();
			mismatches = 0;
			hits = 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (rsp.duplicate === 1'b1) hits++;
				if (dup_expected.size() == 0) begin
					report_mismatch($sformatf("duplicate=%0b with no request outstanding",
						rsp.duplicate));
				end else begin
					exp_dup = dup_expected.pop_front();
					if (rsp.duplicate !== exp_dup)
						report_mismatch($sformatf("duplicate=%0b, expected %0b",
							rsp.duplicate, exp_dup));
				end
			end
			if (req.valid && req.ready)
				dup_expected.push_back(apply_request(req.func, req.sequence_req, req.now_ms));
			if (cfg.valid && cfg.ready)
				window = cfg.replay_window_ms;
			pending <= dup_expected.size();
		end
	end

endmodule

### test/testbench.sv
// Top of the sequence replay filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
	import srf_pkg::*;

	localparam int                SEQ_ENTRIES  = 256;
	localparam int unsigned       CYCLE_LIMIT  = 400_000;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
	localparam int                PHASE_ITEMS  = 310;
	localparam int                HOLD_CYCLES  = 400;

	logic clk;
	logic arst_n;

	srf_req_if req();
	srf_rsp_if rsp();
	srf_cfg_if cfg();

	int unsigned mismatches;
	int unsigned hits;
	int unsigned pending;
	int unsigned cycle_count;
	int unsigned sent;
	int unsigned clears_sent;

	int                send_idle_pct;
	int                recv_idle_pct;
	bit                hold_go;
	logic              hold_off;
	logic [TIME_W-1:0] now_cursor;
	logic [SEQ_W-1:0]  seq_pool [16];

	sequence_replay_filter_unit #(.SEQ_ENTRIES(SEQ_ENTRIES)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	replay_filter_checker #(.SEQ_ENTRIES(SEQ_ENTRIES)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.mismatches (mismatches),
		.hits       (hits),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// long receiver hold-off so the block backs up into the request channel
	initial begin
		hold_off = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SEQ_W-1:0] s,
			input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.func         <= f;
		req.sequence_req <= s;
		req.now_ms       <= t;
		do @(posedge clk); while (!req.ready);
		sent++;
		if (f == FUNC_CLEAR) clears_sent++;
	endtask

	task automatic settle;
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [TIME_W-1:0] w);
		settle();
		cfg.valid            <= 1'b1;
		cfg.replay_window_ms <= w;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_random;
		int                r;
		logic [FUNC_W-1:0] f;
		logic [SEQ_W-1:0]  s;
		logic [TIME_W-1:0] t;
		r = $urandom_range(99);
		if (r < 2) f = FUNC_CLEAR;
		else if (r < 5) f = FUNC_UNUSED;
		else if (r < 45) f = FUNC_COMMIT;
		else f = FUNC_CHECK;
		if ($urandom_range(99) < 70) s = seq_pool[$urandom_range(15)];
		else s = SEQ_W'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 3) now_cursor = $urandom;
		else if (r >= 25) now_cursor += $urandom_range(400);
		t = now_cursor;
		// late frame stamped in the past
		if ($urandom_range(99) < 4) t = now_cursor - $urandom_range(600);
		send_item(f, s, t);
	endtask

	initial begin
		logic [TIME_W-1:0] windows [6];
		arst_n               = 1'b0;
		req.valid            = 1'b0;
		req.func             = FUNC_CHECK;
		req.sequence_req     = '0;
		req.now_ms           = '0;
		rsp.ready            = 1'b0;
		cfg.valid            = 1'b0;
		cfg.replay_window_ms = '0;
		cycle_count          = 0;
		sent                 = 0;
		clears_sent          = 0;
		hold_go              = 1'b0;
		send_idle_pct        = 21;
		recv_idle_pct        = 72;
		foreach (seq_pool[i]) seq_pool[i] = SEQ_W'($urandom_range(255));
		windows[0] = WINDOW_RESET;
		windows[1] = 32'd0;
		windows[2] = 32'hFFFF_FFFF;
		windows[3] = 32'd250;
		windows[4] = $urandom_range(20000, 2000);
		windows[5] = 32'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset window, boundaries, wrap, unused code, clear, window 0 and all-ones
		send_item(FUNC_CHECK,  8'd0,   32'd0);
		send_item(FUNC_COMMIT, 8'd0,   32'd0);
		send_item(FUNC_CHECK,  8'd0,   32'd1000);
		send_item(FUNC_CHECK,  8'd0,   32'd1001);
		send_item(FUNC_COMMIT, 8'd255, 32'hFFFF_FFFF);
		send_item(FUNC_CHECK,  8'd255, 32'd999);
		send_item(FUNC_CHECK,  8'd255, 32'hFFFF_FFF0);
		send_item(FUNC_UNUSED, 8'd255, 32'd0);
		send_item(FUNC_CHECK,  8'd255, 32'hFFFF_FFFF);
		send_item(FUNC_CLEAR,  8'd0,   32'd0);
		send_item(FUNC_CHECK,  8'd255, 32'hFFFF_FFFF);
		send_item(FUNC_CHECK,  8'd0,   32'd0);
		send_item(FUNC_COMMIT, 8'd170, 32'hAAAA_AAAA);
		send_item(FUNC_CHECK,  8'd170, 32'h5555_5555);
		send_item(FUNC_COMMIT, 8'd85,  32'h5555_5555);
		send_item(FUNC_CHECK,  8'd85,  32'h5555_5555);
		write_window(32'd0);
		send_item(FUNC_COMMIT, 8'd1,   32'd77);
		send_item(FUNC_CHECK,  8'd1,   32'd77);
		send_item(FUNC_CHECK,  8'd1,   32'd78);
		write_window(32'hFFFF_FFFF);
		send_item(FUNC_CHECK,  8'd170, 32'd0);
		send_item(FUNC_CHECK,  8'd255, 32'd0);

		for (int p = 0; p < 6; p++) begin
			write_window(windows[p]);
			if (p == 2) begin
				send_idle_pct = 72;
				recv_idle_pct = 21;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 0) hold_go = 1'b1;
			now_cursor = $urandom;
			for (int i = 0; i < PHASE_ITEMS; i++) send_random();
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests (%0d table clears) across six window settings,",
			sent, clears_sent);
		$display("window 0 and all-ones included; %0d responses flagged duplicate.", hits);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/srf_pkg.sv
rtl/core/srf_req_if.sv
rtl/core/srf_rsp_if.sv
rtl/core/srf_cfg_if.sv
rtl/core/srf_ram.sv
rtl/core/srf_dp.sv
rtl/core/srf_ctrl.sv
rtl/core/sequence_replay_filter_unit.sv
test/replay_filter_checker.sv
test/testbench.sv
